// ----- hdl/stbs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package stbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int DATA_W      = 32;
	localparam int INDEX_W     = 10;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int SIZE_W      = 11;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic [0:0] REG_TABLE_SIZE = 1'b0;

	typedef struct packed {
		logic load;
		logic step;
		logic rd;
		logic wr;
	} stbs_cmd_t;

	typedef struct packed {
		logic hit;
		logic empty;
	} stbs_sts_t;

endpackage
`default_nettype wire

// ----- hdl/stbs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/stbs_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module stbs_dp (
	input  wire logic                                 clk,
	input  wire stbs_pkg::stbs_cmd_t                  cmd_in,
	output stbs_pkg::stbs_sts_t                       sts_out,
	input  wire logic [stbs_pkg::INDEX_W-1:0]         entry_index,
	input  wire logic signed [stbs_pkg::DATA_W-1:0]   key_value,
	input  wire logic [stbs_pkg::SIZE_W-1:0]          table_size
);

	logic signed [stbs_pkg::DATA_W-1:0] key_q;
	logic [stbs_pkg::CNT_W-1:0]         low_q;
	logic [stbs_pkg::CNT_W-1:0]         hie_q;
	logic [stbs_pkg::ADDR_W-1:0]        mid_q;
	logic [stbs_pkg::CNT_W-1:0]         count;
	logic [stbs_pkg::CNT_W-1:0]         nxt_low;
	logic [stbs_pkg::CNT_W-1:0]         nxt_hie;
	logic [stbs_pkg::CNT_W:0]           mid_sum;
	logic [stbs_pkg::ADDR_W-1:0]        nxt_mid;
	logic [stbs_pkg::DATA_W-1:0]        rd_data;
	logic signed [stbs_pkg::DATA_W-1:0] probe_val;
	logic                               key_lt;

	// saturate the size to the table depth
	always_comb begin
		if (table_size > stbs_pkg::SIZE_W'(stbs_pkg::TABLE_DEPTH)) begin
			count = stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH);
		end else begin
			count = stbs_pkg::CNT_W'(table_size);
		end
	end

	assign probe_val = $signed(rd_data);
	assign key_lt    = key_q < probe_val;

	// range kept as [low, hie) with exclusive upper bound
	always_comb begin
		priority if (cmd_in.load) begin
			nxt_low = '0;
			nxt_hie = count;
		end else if (cmd_in.step) begin
			if (key_lt) begin
				nxt_low = low_q;
				nxt_hie = {1'b0, mid_q};
			end else begin
				nxt_low = {1'b0, mid_q} + stbs_pkg::CNT_W'(1);
				nxt_hie = hie_q;
			end
		end else begin
			nxt_low = low_q;
			nxt_hie = hie_q;
		end
	end

	assign mid_sum = {1'b0, nxt_low} + {1'b0, nxt_hie} - (stbs_pkg::CNT_W + 1)'(1);
	assign nxt_mid = mid_sum[stbs_pkg::ADDR_W:1];

	assign sts_out.hit   = (probe_val == key_q);
	assign sts_out.empty = !(nxt_low < nxt_hie);

	always_ff @(posedge clk) begin
		if (cmd_in.load) begin
			key_q <= key_value;
		end
		if (cmd_in.load || cmd_in.step) begin
			low_q <= nxt_low;
			hie_q <= nxt_hie;
			mid_q <= nxt_mid;
		end
	end

	stbs_ram #(
		.WIDTH (stbs_pkg::DATA_W),
		.DEPTH (stbs_pkg::TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (cmd_in.wr),
		.wr_addr (entry_index),
		.wr_data (key_value),
		.rd_en   (cmd_in.rd),
		.rd_addr (nxt_mid),
		.rd_data (rd_data)
	);

endmodule
`default_nettype wire

// ----- hdl/stbs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module stbs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                cmd,
	output logic                     busy,
	output logic                     done,
	output logic                     found,
	output stbs_pkg::stbs_cmd_t      cmd_out,
	input  wire stbs_pkg::stbs_sts_t sts_in
);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_PROBE = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   done_q;
	logic   found_q;
	logic   done_nxt;
	logic   found_nxt;

	assign busy  = (state_q == S_PROBE);
	assign done  = done_q;
	assign found = found_q;

	always_comb begin
		cmd_out   = '0;
		state_nxt = state_q;
		done_nxt  = 1'b0;
		found_nxt = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_out.load = start && (cmd == stbs_pkg::CMD_SEARCH);
				cmd_out.wr   = start && (cmd == stbs_pkg::CMD_WRITE);
				cmd_out.rd   = cmd_out.load && !sts_in.empty;
				if (cmd_out.load) begin
					if (sts_in.empty) begin
						done_nxt = 1'b1;
					end else begin
						state_nxt = S_PROBE;
					end
				end
			end
			S_PROBE: begin
				cmd_out.step = !sts_in.hit;
				cmd_out.rd   = !sts_in.hit && !sts_in.empty;
				if (sts_in.hit || sts_in.empty) begin
					done_nxt  = 1'b1;
					found_nxt = sts_in.hit;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= done_nxt;
			found_q <= found_nxt;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/sorted_table_binary_search_core.sv -----
// Sorted table binary search core.
// Software fills a table of 1024 signed 32-bit entries in ascending order
// and then looks up keys. One request channel: start with cmd, entry_index
// and key_value is taken at a rising edge where start is high and busy low.
// cmd write stores key_value at entry_index and gives no result.
// cmd search gives exactly one result: done high for one cycle with found.
// The APB port holds table_size at byte address 0; pready is always high.
// A search makes at most 11 probes for a full table, from request to
// result: each probe is one read of the table RAM, and the next probe
// address is formed in the cycle the data returns.
// busy is high only during the probe cycles; a new request can be taken in
// the cycle its result is shown. An empty table answers in the next cycle.
// The receiver cannot stall: done lasts exactly one cycle.
// Reset clears table_size and the controller; the table contents are
// undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module sorted_table_binary_search_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                cmd,
	input  wire logic [stbs_pkg::INDEX_W-1:0]        entry_index,
	input  wire logic signed [stbs_pkg::DATA_W-1:0]  key_value,
	output logic                                     done,
	output logic                                     found,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [stbs_pkg::PADDR_W-1:0]        paddr,
	input  wire logic [stbs_pkg::PDATA_W-1:0]        pwdata,
	output logic      [stbs_pkg::PDATA_W-1:0]        prdata,
	output logic                                     pready
);

	logic [stbs_pkg::SIZE_W-1:0] table_size_q;
	logic                        reg_sel;
	stbs_pkg::stbs_cmd_t         dp_cmd;
	stbs_pkg::stbs_sts_t         dp_sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[stbs_pkg::PADDR_W-1:2] == stbs_pkg::REG_TABLE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= '0;
		end else if (psel && penable && pwrite && reg_sel) begin
			table_size_q <= pwdata[stbs_pkg::SIZE_W-1:0];
		end
	end

	always_comb begin
		if (reg_sel) begin
			prdata = stbs_pkg::PDATA_W'(table_size_q);
		end else begin
			prdata = '0;
		end
	end

	stbs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.found   (found),
		.cmd_out (dp_cmd),
		.sts_in  (dp_sts)
	);

	stbs_dp u_dp (
		.clk         (clk),
		.cmd_in      (dp_cmd),
		.sts_out     (dp_sts),
		.entry_index (entry_index),
		.key_value   (key_value),
		.table_size  (table_size_q)
	);

endmodule
`default_nettype wire

// ----- hdl/stbs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module stbs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic cmd,
	input wire logic done,
	input wire logic found
);

	// every result comes from a search request or a probe cycle
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && (cmd == stbs_pkg::CMD_SEARCH))))
		else $error("result without a search request");

	a_found_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		found |-> done)
		else $error("found outside a result cycle");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == stbs_pkg::CMD_WRITE)) |=> !done)
		else $error("result after a write request");

	a_busy_from_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && (cmd == stbs_pkg::CMD_SEARCH)))
		else $error("busy without a search request");

	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("search ended without a result");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.found  (found)
);
`default_nettype wire
